### src/fbdc_pkg.sv
// Shared types and constants for the FM0 bit detector with CRC-16 check.
// No dependencies; every other file of the block refers to this package.
package fbdc_pkg;

  // Sample and metric widths
  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + SAMPLE_W;
  localparam int SUM_W    = PROD_W + 1;

  // Configuration port
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_RE = 2'd0,
    CFG_CHANNEL_IM = 2'd1,
    CFG_CRC_ENABLE = 2'd2
  } cfg_idx_t;

  localparam logic signed [SAMPLE_W-1:0] CHAN_RE_RESET = SAMPLE_W'(32767);
  localparam logic signed [SAMPLE_W-1:0] CHAN_IM_RESET = '0;
  localparam logic                       CRC_EN_RESET  = 1'b1;

  // CRC-16 CCITT
  localparam int              CRC_W    = 16;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // Bit counter saturates at CRC_W; its top bit flags a full tail
  localparam int BITS_W = 5;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int LEVEL_W    = FIFO_AW + 1;

  // One classified symbol
  typedef struct packed {
    logic sign;  // 1 means metric > 0
    logic last;
  } sym_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic               empty;
    logic [LEVEL_W-1:0] level;
  } fifo_stat_t;

endpackage

### src/fbdc_if.sv
// Channel interfaces: symbol input, decoded-bit output and register writes.
// Depends on fbdc_pkg for widths.

interface fbdc_in_if (input logic clk);
  logic                                 valid;
  logic                                 ready;
  logic signed [fbdc_pkg::SAMPLE_W-1:0] first_re;
  logic signed [fbdc_pkg::SAMPLE_W-1:0] first_im;
  logic signed [fbdc_pkg::SAMPLE_W-1:0] second_re;
  logic signed [fbdc_pkg::SAMPLE_W-1:0] second_im;
  logic                                 frame_last;

  modport source (input clk, input ready,
                  output valid, first_re, first_im, second_re, second_im, frame_last);
  modport sink   (input clk, input valid, first_re, first_im, second_re, second_im,
                  frame_last, output ready);
endinterface

interface fbdc_out_if (input logic clk);
  logic valid;
  logic ready;
  logic decoded_bit;
  logic frame_end;
  logic crc_ok;

  modport source (input clk, input ready, output valid, decoded_bit, frame_end, crc_ok);
  modport sink   (input clk, input valid, decoded_bit, frame_end, crc_ok, output ready);
endinterface

interface fbdc_cfg_if (input logic clk);
  logic                                 valid;
  logic                                 ready;
  logic [fbdc_pkg::CFG_IDX_W-1:0]       index;
  logic signed [fbdc_pkg::SAMPLE_W-1:0] data;

  modport source (input clk, input ready, output valid, index, data);
  modport sink   (input clk, input valid, index, data, output ready);
endinterface

### src/fm0_bit_detect_crc16_check_unit.sv
// Top level of the FM0 bit detector with trailing CRC-16 check.
// Depends on fbdc_pkg, fbdc_if.sv, fbdc_front, fbdc_fifo and fbdc_back.
//
// Usage:
//   in_ch   takes one FM0 symbol per transfer: the first and second half-bit
//           complex samples and a frame_last flag on the frame's final symbol.
//   out_ch  gives one result per symbol: the decoded bit, frame_end, and
//           crc_ok, which is 1 only on a frame's last symbol when checking is
//           enabled and the complemented CRC-16 CCITT of all but the last 16
//           bits equals those 16 bits.
//   cfg_ch  writes the channel estimate (index 0 real, 1 imaginary) and the
//           check enable (index 2); write only while no symbol is in flight.
// Path: a symbol taken on in_ch passes the product register, then the queue
//   and the output register, before it is offered on out_ch.
// Throughput: one symbol per cycle while out_ch takes results, set by the one
//   multiply stage and the combinational decode/CRC step in the back part.
// Reset (synchronous, rst_n low) loads the register defaults, empties the
//   queue and starts a new frame. When out_ch stalls, results collect in the
//   four-entry queue; in_ch.ready drops once the queue has no room left.
module fm0_bit_detect_crc16_check_unit (
  input  logic       clk,
  input  logic       rst_n,
  fbdc_in_if.sink    in_ch,
  fbdc_out_if.source out_ch,
  fbdc_cfg_if.sink   cfg_ch
);

  logic                 push;
  logic                 pop;
  logic                 crc_en;
  fbdc_pkg::sym_t       push_data;
  fbdc_pkg::sym_t       pop_data;
  fbdc_pkg::fifo_stat_t fifo_stat;

  fbdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data),
    .crc_en    (crc_en)
  );

  fbdc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  fbdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .sym       (pop_data),
    .crc_en    (crc_en),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // The accept credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_stat.level != fbdc_pkg::LEVEL_W'(fbdc_pkg::FIFO_DEPTH)))
    else $error("symbol pushed into a full queue");

  // The back part takes only what is there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("pop from an empty queue");

  // A result appears only after a symbol left the queue
  a_out_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(pop))
    else $error("result shown without a queued symbol");

endmodule

### src/fbdc_front.sv
// Front part: configuration registers, symbol accept and metric sign.
// Depends on fbdc_pkg and the channel interfaces in fbdc_if.sv.
module fbdc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  fbdc_in_if.sink              in_ch,
  fbdc_cfg_if.sink             cfg_ch,
  input  fbdc_pkg::fifo_stat_t fifo_stat,
  output logic                 push,
  output fbdc_pkg::sym_t       push_data,
  output logic                 crc_en
);

  logic signed [fbdc_pkg::SAMPLE_W-1:0] chan_re_r;
  logic signed [fbdc_pkg::SAMPLE_W-1:0] chan_im_r;
  logic                                 crc_en_r;

  logic signed [fbdc_pkg::DIFF_W-1:0]   d_re;
  logic signed [fbdc_pkg::DIFF_W-1:0]   d_im;
  logic signed [fbdc_pkg::PROD_W-1:0]   prod_re;
  logic signed [fbdc_pkg::PROD_W-1:0]   prod_im;
  logic signed [fbdc_pkg::PROD_W-1:0]   prod_re_r;
  logic signed [fbdc_pkg::PROD_W-1:0]   prod_im_r;
  logic                                 last_r;
  logic                                 s1_valid_r;
  logic signed [fbdc_pkg::SUM_W-1:0]    metric;
  logic [fbdc_pkg::LEVEL_W:0]           occupancy;
  logic                                 in_xfer;

  // Register writes, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_re_r <= fbdc_pkg::CHAN_RE_RESET;
      chan_im_r <= fbdc_pkg::CHAN_IM_RESET;
      crc_en_r  <= fbdc_pkg::CRC_EN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (fbdc_pkg::cfg_idx_t'(cfg_ch.index))
        fbdc_pkg::CFG_CHANNEL_RE: chan_re_r <= cfg_ch.data;
        fbdc_pkg::CFG_CHANNEL_IM: chan_im_r <= cfg_ch.data;
        fbdc_pkg::CFG_CRC_ENABLE: crc_en_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign crc_en = crc_en_r;

  // Accept only when the queue can hold this symbol and the one in flight
  assign occupancy = {1'b0, fifo_stat.level} + {{fbdc_pkg::LEVEL_W{1'b0}}, s1_valid_r};
  assign in_ch.ready = occupancy < (fbdc_pkg::LEVEL_W + 1)'(fbdc_pkg::FIFO_DEPTH);
  assign in_xfer = in_ch.valid && in_ch.ready;

  // Half-bit difference times channel estimate
  assign d_re    = fbdc_pkg::DIFF_W'(in_ch.first_re) - fbdc_pkg::DIFF_W'(in_ch.second_re);
  assign d_im    = fbdc_pkg::DIFF_W'(in_ch.first_im) - fbdc_pkg::DIFF_W'(in_ch.second_im);
  assign prod_re = d_re * chan_re_r;
  assign prod_im = d_im * chan_im_r;

  // Register the products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      prod_re_r <= prod_re;
      prod_im_r <= prod_im;
      last_r    <= in_ch.frame_last;
    end
  end

  // Sum and take the sign; a zero metric counts as negative
  assign metric = fbdc_pkg::SUM_W'(prod_re_r) + fbdc_pkg::SUM_W'(prod_im_r);

  assign push           = s1_valid_r;
  assign push_data.sign = !metric[fbdc_pkg::SUM_W-1] && (metric != '0);
  assign push_data.last = last_r;

endmodule

### src/fbdc_fifo.sv
// Short queue of classified symbols between front and back.
// Depends on fbdc_pkg for the entry and status types.
module fbdc_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fbdc_pkg::sym_t       push_data,
  input  logic                 pop,
  output fbdc_pkg::sym_t       pop_data,
  output fbdc_pkg::fifo_stat_t stat
);

  fbdc_pkg::sym_t                slot_r [fbdc_pkg::FIFO_DEPTH];
  logic [fbdc_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [fbdc_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [fbdc_pkg::LEVEL_W-1:0]  level_r;
  logic [fbdc_pkg::LEVEL_W-1:0]  level_nxt;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_comb begin
    level_nxt = level_r;
    case ({push, pop})
      2'b10:   level_nxt = level_r + 1'b1;
      2'b01:   level_nxt = level_r - 1'b1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      level_r <= level_nxt;
    end
  end

  assign pop_data   = slot_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.empty = (level_r == '0);

endmodule

### src/fbdc_back.sv
// Back part: differential decode, CRC-16 tracking and the output register.
// Depends on fbdc_pkg and the output interface in fbdc_if.sv.
module fbdc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fbdc_pkg::fifo_stat_t fifo_stat,
  input  fbdc_pkg::sym_t       sym,
  input  logic                 crc_en,
  output logic                 pop,
  fbdc_out_if.source           out_ch
);

  logic                             prev_sign_r;
  logic                             prev_sign_nxt;
  logic [fbdc_pkg::CRC_W-1:0]       crc_r;
  logic [fbdc_pkg::CRC_W-1:0]       crc_nxt;
  logic [fbdc_pkg::CRC_W-1:0]       crc_fed;
  logic [fbdc_pkg::CRC_W-1:0]       tail_r;
  logic [fbdc_pkg::CRC_W-1:0]       tail_nxt;
  logic [fbdc_pkg::CRC_W-1:0]       tail_upd;
  logic [fbdc_pkg::BITS_W-1:0]      bits_r;
  logic [fbdc_pkg::BITS_W-1:0]      bits_nxt;
  logic [fbdc_pkg::BITS_W-1:0]      bits_upd;
  logic [fbdc_pkg::CRC_W-1:0]       crc_mix;
  logic                             bit_val;
  logic                             ok_val;
  logic                             out_valid_r;
  logic                             bit_r;
  logic                             end_r;
  logic                             ok_r;

  // Take a symbol when the output register is free or being drained
  assign pop = !fifo_stat.empty && (!out_valid_r || out_ch.ready);

  // Decode and CRC step for the symbol at the queue head
  always_comb begin
    bit_val = sym.sign ^ prev_sign_r;

    // Shift out the oldest tail bit into the CRC once the tail is full
    crc_mix = crc_r ^ {tail_r[fbdc_pkg::CRC_W-1], {(fbdc_pkg::CRC_W-1){1'b0}}};
    if (!bits_r[fbdc_pkg::BITS_W-1]) begin
      crc_fed = crc_r;
    end else if (crc_mix[fbdc_pkg::CRC_W-1]) begin
      crc_fed = {crc_mix[fbdc_pkg::CRC_W-2:0], 1'b0} ^ fbdc_pkg::CRC_POLY;
    end else begin
      crc_fed = {crc_mix[fbdc_pkg::CRC_W-2:0], 1'b0};
    end

    tail_upd = {tail_r[fbdc_pkg::CRC_W-2:0], bit_val};
    bits_upd = bits_r[fbdc_pkg::BITS_W-1] ? bits_r : bits_r + 1'b1;

    ok_val = sym.last && crc_en && bits_upd[fbdc_pkg::BITS_W-1] && (~crc_fed == tail_upd);

    // Frame end returns the frame state to its start values
    if (sym.last) begin
      prev_sign_nxt = 1'b1;
      crc_nxt       = fbdc_pkg::CRC_INIT;
      tail_nxt      = '0;
      bits_nxt      = '0;
    end else begin
      prev_sign_nxt = sym.sign;
      crc_nxt       = crc_fed;
      tail_nxt      = tail_upd;
      bits_nxt      = bits_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sign_r <= 1'b1;
      crc_r       <= fbdc_pkg::CRC_INIT;
      tail_r      <= '0;
      bits_r      <= '0;
    end else if (pop) begin
      prev_sign_r <= prev_sign_nxt;
      crc_r       <= crc_nxt;
      tail_r      <= tail_nxt;
      bits_r      <= bits_nxt;
    end
  end

  // Output register: load on pop, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bit_r <= bit_val;
      end_r <= sym.last;
      ok_r  <= ok_val;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.decoded_bit = bit_r;
  assign out_ch.frame_end   = end_r;
  assign out_ch.crc_ok      = ok_r;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for fm0_bit_detect_crc16_check_unit: directed table, then random frames.
// Depends on fbdc_pkg and the channel interfaces in fbdc_if.sv.

module tb;

  localparam int ITEMS_TOTAL  = 1250;
  localparam int LIMIT_CYCLES = 800000;
  localparam int PHASE_ITEMS  = 110;
  localparam int DIR_ROWS     = 22;

  // Index with no register behind it; writes there must be dropped
  localparam logic [fbdc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef logic signed [fbdc_pkg::SAMPLE_W-1:0] q15_t;

  typedef struct {
    q15_t fr;
    q15_t fi;
    q15_t sr;
    q15_t si;
    bit   last;
  } fm0_sym_t;

  typedef struct packed {
    bit decoded;
    bit frame_end;
    bit crc_ok;
  } fm0_res_t;

  typedef struct {
    bit       typed;
    fm0_res_t res;
  } sym_note_t;

  typedef struct packed {
    q15_t     fr;
    q15_t     fi;
    q15_t     sr;
    q15_t     si;
    bit       last;
    fm0_res_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fbdc_in_if  in_ch  (.clk(clk));
  fbdc_out_if out_ch (.clk(clk));
  fbdc_cfg_if cfg_ch (.clk(clk));

  fm0_bit_detect_crc16_check_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register shadow, updated on each cfg transfer
  q15_t chan_re  = fbdc_pkg::CHAN_RE_RESET;
  q15_t chan_im  = fbdc_pkg::CHAN_IM_RESET;
  bit   check_en = fbdc_pkg::CRC_EN_RESET;

  // Frame state of the decoder
  bit                         sign_pos   = 1'b1;
  logic [fbdc_pkg::CRC_W-1:0] crc_acc    = fbdc_pkg::CRC_INIT;
  logic [fbdc_pkg::CRC_W-1:0] tail_shift = '0;
  int                         tail_count = 0;

  fm0_res_t  bits_due[$];
  sym_note_t notes_q[$];

  bit gen_pos = 1'b1;
  bit steady  = 1'b0;
  int items_sent  = 0;
  int items_taken = 0;
  int frames_done = 0;
  int crc_pass    = 0;
  int reg_writes  = 0;
  int phases      = 0;
  int err_count   = 0;
  int cycle_count = 0;

  // Reset-state table: extremes, zero metric, short frames, minimal good frame
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ 32767,  32767, -32768, -32768, 1'b0, 3'b000},
    '{-32768, -32768,  32767,  32767, 1'b0, 3'b100},
    '{     0,      0,      0,      0, 1'b0, 3'b000},
    '{-32768,  32767, -32768, -32768, 1'b1, 3'b010},
    '{     1,      0,      0,      0, 1'b1, 3'b010},
    '{    -1,      0,      0,      0, 1'b1, 3'b110},
    '{ 16384,      0, -16384,      0, 1'b0, 3'b000},
    '{     1, -32768,      0,  32767, 1'b0, 3'b000},
    '{ 32767,  32767,  32766, -32768, 1'b0, 3'b000},
    '{-32767,      5, -32768,     -5, 1'b0, 3'b000},
    '{     0,      0,     -1,      0, 1'b0, 3'b000},
    '{   200,   -200,   -300,    300, 1'b0, 3'b000},
    '{ 32767,     -1,      0,     -1, 1'b0, 3'b000},
    '{    -1,  21845,     -2, -21846, 1'b0, 3'b000},
    '{ 12345,      0,      0,      0, 1'b0, 3'b000},
    '{     0,  32767, -32768,  32767, 1'b0, 3'b000},
    '{   100,    100,     99,     99, 1'b0, 3'b000},
    '{     7,     -7,     -7,      7, 1'b0, 3'b000},
    '{ 30000,      0, -30000,      0, 1'b0, 3'b000},
    '{  -100, -32768,   -200, -32768, 1'b0, 3'b000},
    '{  1024,   4096,  -1024,   8192, 1'b0, 3'b000},
    '{     2,      0,      1,      0, 1'b1, 3'b011}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact Re((a - b) * conj(h)) under the current channel estimate
  function automatic longint symbol_metric(fm0_sym_t s);
    return (longint'(s.fr) - longint'(s.sr)) * longint'(chan_re) +
           (longint'(s.fi) - longint'(s.si)) * longint'(chan_im);
  endfunction

  function automatic logic [fbdc_pkg::CRC_W-1:0] fold_crc_bit(
      logic [fbdc_pkg::CRC_W-1:0] c, bit b);
    logic [fbdc_pkg::CRC_W-1:0] t;
    t = c ^ {b, {(fbdc_pkg::CRC_W-1){1'b0}}};
    return t[fbdc_pkg::CRC_W-1] ? ({t[fbdc_pkg::CRC_W-2:0], 1'b0} ^ fbdc_pkg::CRC_POLY)
                                : {t[fbdc_pkg::CRC_W-2:0], 1'b0};
  endfunction

  function void clear_frame();
    sign_pos   = 1'b1;
    crc_acc    = fbdc_pkg::CRC_INIT;
    tail_shift = '0;
    tail_count = 0;
  endfunction

  // Decode one symbol and advance the frame state
  function automatic fm0_res_t decode_symbol(fm0_sym_t s);
    fm0_res_t r;
    bit pos;
    pos         = symbol_metric(s) > 0;
    r.decoded   = (pos != sign_pos);
    r.frame_end = s.last;
    r.crc_ok    = 1'b0;
    sign_pos    = pos;
    if (tail_count >= fbdc_pkg::CRC_W)
      crc_acc = fold_crc_bit(crc_acc, tail_shift[fbdc_pkg::CRC_W-1]);
    tail_shift = {tail_shift[fbdc_pkg::CRC_W-2:0], r.decoded};
    if (tail_count < fbdc_pkg::CRC_W)
      tail_count++;
    if (s.last) begin
      r.crc_ok = check_en && (tail_count >= fbdc_pkg::CRC_W) && ((~crc_acc) == tail_shift);
      clear_frame();
    end
    return r;
  endfunction

  function automatic q15_t pick_q15();
    case ($urandom_range(0, 9))
      0: return q15_t'(-32768);
      1: return q15_t'(32767);
      2: return '0;
      default: return q15_t'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random samples whose metric has the wanted sign, swapping halves to flip it
  function automatic fm0_sym_t make_symbol(bit want_pos, bit last);
    fm0_sym_t s;
    q15_t     t;
    longint   m;
    s.last = last;
    for (int k = 0; k < 8; k++) begin
      s.fr = pick_q15();
      s.fi = pick_q15();
      s.sr = pick_q15();
      s.si = pick_q15();
      m = symbol_metric(s);
      if ((m > 0) == want_pos)
        break;
      if (m != 0) begin
        t = s.fr; s.fr = s.sr; s.sr = t;
        t = s.fi; s.fi = s.si; s.si = t;
        break;
      end
    end
    return s;
  endfunction

  // Drive one symbol and hold it until the transfer
  task automatic put_symbol(fm0_sym_t s, bit typed, fm0_res_t res);
    sym_note_t note;
    int gap;
    gap = 0;
    if (!steady)
      gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.first_re   <= s.fr;
    in_ch.first_im   <= s.fi;
    in_ch.second_re  <= s.sr;
    in_ch.second_im  <= s.si;
    in_ch.frame_last <= s.last;
    note.typed = typed;
    note.res   = res;
    notes_q = {notes_q, note};
    gen_pos = s.last ? 1'b1 : (symbol_metric(s) > 0);
    items_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bits_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [fbdc_pkg::CFG_IDX_W-1:0] idx, q15_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic write_all(q15_t re, q15_t im, bit en);
    q15_t en_word;
    en_word    = q15_t'($urandom);
    en_word[0] = en;
    write_reg(fbdc_pkg::CFG_CHANNEL_RE, re);
    write_reg(fbdc_pkg::CFG_CHANNEL_IM, im);
    write_reg(fbdc_pkg::CFG_CRC_ENABLE, en_word);
    write_reg(CFG_IDX_SPARE, pick_q15());
  endtask

  // Mostly well-formed frames with a valid CRC tail, some corrupted, some noise
  task automatic send_frame();
    bit                         frame_bits[$];
    logic [fbdc_pkg::CRC_W-1:0] c;
    fm0_sym_t                   s;
    fm0_res_t                   none;
    int                         kind, n, plen, pause_at;
    bit                         b;
    none = '0;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        s = make_symbol($urandom_range(0, 1), i == n - 1);
        put_symbol(s, 1'b0, none);
      end
    end else begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
      c = fbdc_pkg::CRC_INIT;
      for (int i = 0; i < plen; i++) begin
        b = $urandom_range(0, 1);
        frame_bits = {frame_bits, b};
        c = fold_crc_bit(c, b);
      end
      c = ~c;
      for (int i = fbdc_pkg::CRC_W - 1; i >= 0; i--)
        frame_bits = {frame_bits, c[i]};
      if (kind < 30) begin
        n = $urandom_range(0, frame_bits.size() - 1);
        frame_bits[n] = ~frame_bits[n];
      end
      n = frame_bits.size();
      pause_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        // retune the channel mid-frame while the block is idle
        if (i == pause_at) begin
          drain_results();
          write_reg(fbdc_pkg::CFG_CHANNEL_RE, pick_q15());
          write_reg(fbdc_pkg::CFG_CHANNEL_IM, pick_q15());
        end
        s = make_symbol(frame_bits[i] ? !gen_pos : gen_pos, i == n - 1);
        put_symbol(s, 1'b0, none);
      end
    end
  endtask

  // Check results, predict accepted symbols, track register writes
  always @(posedge clk) begin
    fm0_sym_t  s;
    fm0_res_t  got, want;
    sym_note_t note;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.decoded_bit, out_ch.frame_end, out_ch.crc_ok};
        if (bits_due.size() == 0) begin
          $error("result with nothing pending: bit %0d end %0d ok %0d",
                 got.decoded, got.frame_end, got.crc_ok);
          err_count++;
        end else begin
          want = bits_due.pop_front();
          if (got.decoded !== want.decoded) begin
            $error("decoded_bit: expected %0d, got %0d", want.decoded, got.decoded);
            err_count++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
            err_count++;
          end
          if (got.crc_ok !== want.crc_ok) begin
            $error("crc_ok: expected %0d, got %0d", want.crc_ok, got.crc_ok);
            err_count++;
          end
        end
        if (got.frame_end) frames_done++;
        if (got.crc_ok) crc_pass++;
      end
      if (in_ch.valid && in_ch.ready) begin
        s.fr   = in_ch.first_re;
        s.fi   = in_ch.first_im;
        s.sr   = in_ch.second_re;
        s.si   = in_ch.second_im;
        s.last = in_ch.frame_last;
        note = notes_q.pop_front();
        want = decode_symbol(s);
        if (note.typed)
          want = note.res;
        bits_due = {bits_due, want};
        items_taken++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          fbdc_pkg::CFG_CHANNEL_RE: chan_re  = cfg_ch.data;
          fbdc_pkg::CFG_CHANNEL_IM: chan_im  = cfg_ch.data;
          fbdc_pkg::CFG_CRC_ENABLE: check_en = cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  // Result side: random stalls, none while steady
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat (steady ? 1 : $urandom_range(1, 16)) @(posedge clk);
      if (!steady) begin
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    int       phase_end;
    q15_t     re, im;
    bit       en;
    fm0_sym_t s;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.first_re   <= '0;
    in_ch.first_im   <= '0;
    in_ch.second_re  <= '0;
    in_ch.second_im  <= '0;
    in_ch.frame_last <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= fbdc_pkg::CFG_CHANNEL_RE;
    cfg_ch.data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset register values
    for (int i = 0; i < DIR_ROWS; i++) begin
      s.fr   = dir_rows[i].fr;
      s.fi   = dir_rows[i].fi;
      s.sr   = dir_rows[i].sr;
      s.si   = dir_rows[i].si;
      s.last = dir_rows[i].last;
      put_symbol(s, 1'b1, dir_rows[i].res);
    end

    // Random frames over a series of register settings, extremes first
    while (items_sent < ITEMS_TOTAL) begin
      phases++;
      drain_results();
      case (phases)
        1: begin re = 32767;  im = 0;      en = 1'b0; end
        2: begin re = -32768; im = -32768; en = 1'b1; end
        3: begin re = 32767;  im = -32768; en = 1'b1; end
        4: begin re = 0;      im = 0;      en = 1'b1; end
        5: begin re = -32768; im = 32767;  en = 1'b0; end
        6: begin re = 1;      im = -1;     en = 1'b1; end
        default: begin
          re = pick_q15();
          im = pick_q15();
          en = ($urandom_range(0, 3) != 0);
        end
      endcase
      write_all(re, im, en);
      steady    = (phases == 2) || ($urandom_range(0, 4) == 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEMS_TOTAL)
        send_frame();
    end
    steady = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);

    $display("tb: %0d symbols decoded in %0d frames, %0d of them with a matching CRC",
             items_taken, frames_done, crc_pass);
    $display("tb: %0d register settings, %0d register writes, stalls on both channels",
             phases + 1, reg_writes);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/fbdc_pkg.sv
src/fbdc_if.sv
src/fbdc_front.sv
src/fbdc_fifo.sv
src/fbdc_back.sv
src/fm0_bit_detect_crc16_check_unit.sv
test/tb.sv
